/* hw/rtl/qte_pkg.sv */
// Shared types, widths and tables for the quaternion to Euler angle core.
// No dependencies; imported by every module of the core.
package qte_pkg;

   localparam int DATA_WIDTH_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // Q.28 products and their sums stay within +-2^33
   localparam int PW = 32;     // one product in Q.28
   localparam int QW = 36;     // numerators, denominators
   localparam int CW = 36;     // CORDIC x and y
   localparam int AW = 33;     // angle accumulator, Q.30 radians
   localparam int SW = 30;     // saturated asin argument, Q.28
   localparam int RW = 58;     // square root remainder and root
   localparam int OW = 15;     // output angle, Q2.13
   localparam int SQ_STEPS = 29;
   localparam int SQ_TOP   = 56;   // exponent of the first root bit

   localparam logic signed [OW-1:0] HALF_PI_Q13 = 15'sd12868;
   localparam logic signed [QW-1:0] ONE_Q28     = QW'(64'sd268435456);

   // forced result of one lane
   typedef enum logic [1:0] {
      SPEC_NONE,
      SPEC_POS,
      SPEC_NEG,
      SPEC_ZERO
   } spec_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] ang;
      spec_type             spec;
   } lane_type;

   // carried alongside the square root
   typedef struct packed {
      lane_type             roll;
      lane_type             yaw;
      logic signed [SW-1:0] s;
      logic                 clip;
   } sq_pass_type;

   // carried through the CORDIC
   typedef struct packed {
      lane_type roll;
      lane_type pitch;
      lane_type yaw;
      logic     clip;
   } cd_data_type;

   // atan(2^-i) in Q.30, truncated
   function automatic logic signed [AW-1:0] atan_q30(input int i);
      logic signed [AW-1:0] r;
      begin
         unique case (i)
            0:  r = 33'sd843314856;
            1:  r = 33'sd497837829;
            2:  r = 33'sd263043836;
            3:  r = 33'sd133525158;
            4:  r = 33'sd67021686;
            5:  r = 33'sd33543515;
            6:  r = 33'sd16775850;
            7:  r = 33'sd8388437;
            8:  r = 33'sd4194282;
            9:  r = 33'sd2097149;
            10: r = 33'sd1048575;
            11: r = 33'sd524287;
            12: r = 33'sd262143;
            13: r = 33'sd131071;
            14: r = 33'sd65535;
            15: r = 33'sd32767;
            16: r = 33'sd16383;
            17: r = 33'sd8191;
            18: r = 33'sd4095;
            19: r = 33'sd2047;
            20: r = 33'sd1023;
            21: r = 33'sd511;
            22: r = 33'sd255;
            23: r = 33'sd127;
            24: r = 33'sd63;
            25: r = 33'sd31;
            26: r = 33'sd15;
            27: r = 33'sd7;
            28: r = 33'sd3;
            29: r = 33'sd1;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // sign of a value as a forced-angle code
   function automatic spec_type sign_spec(input logic signed [QW-1:0] v);
      spec_type r;
      begin
         if (v == '0)
            r = SPEC_ZERO;
         else if (v[QW-1])
            r = SPEC_NEG;
         else
            r = SPEC_POS;
         return r;
      end
   endfunction

endpackage

/* hw/rtl/quaternion_to_euler_core.sv */
// Quaternion to roll, pitch and yaw converter, fully pipelined.
// Depends on qte_pkg, qte_front, qte_sqrt_cell and qte_cordic_cell.
//
// req_ channel: one quaternion (w, x, y, z, signed, Q1.14 at 16 bits) per item,
// taken when req_valid is high and req_stall low.
// rsp_ channel: roll, pitch, yaw in signed Q2.13 radians plus pitch_clipped,
// taken when rsp_valid is high and rsp_stall low.
// Stages: 4 front stages, 29 square root cells, one CORDIC cell per iteration
// and one output register.
// Throughput: one item per cycle while rsp_ does not stall, set by the chain of
// cells, each of which passes its item on whenever its successor can take it.
// Each cell loads whenever it is empty or its successor moves, so a stall on
// rsp_ first fills the empty cells and reaches req_stall only once every cell
// holds an item. Nothing is lost or repeated under stall.
// Reset clears every valid bit; the pipeline comes out empty and can take an
// item as soon as reset is released.
module quaternion_to_euler_core #(
   parameter int DATA_WIDTH   = qte_pkg::DATA_WIDTH_DEF,
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_WIDTH-1:0]  req_quat_w,
   input  logic signed [DATA_WIDTH-1:0]  req_quat_x,
   input  logic signed [DATA_WIDTH-1:0]  req_quat_y,
   input  logic signed [DATA_WIDTH-1:0]  req_quat_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [qte_pkg::OW-1:0] rsp_roll_angle,
   output logic signed [qte_pkg::OW-1:0] rsp_pitch_angle,
   output logic signed [qte_pkg::OW-1:0] rsp_yaw_angle,
   output logic                          rsp_pitch_clipped
);
   import qte_pkg::*;

   logic        in_ready;

   logic        sq_v [0:SQ_STEPS];
   logic        sq_r [0:SQ_STEPS];
   logic [RW-1:0] sq_rem [0:SQ_STEPS];
   logic [RW-1:0] sq_res [0:SQ_STEPS];
   sq_pass_type sq_p [0:SQ_STEPS];

   logic        cd_v [0:CORDIC_STEPS];
   logic        cd_r [0:CORDIC_STEPS];
   cd_data_type cd_d [0:CORDIC_STEPS];
   cd_data_type cd_first;

   logic        out_ready;
   logic        rsp_valid_ff;
   logic signed [OW-1:0] roll_ff, pitch_ff, yaw_ff;
   logic        clip_ff;

   assign req_stall = !in_ready;

   // products, ratio terms, asin argument
   qte_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .out_valid (sq_v[0]),
      .out_ready (sq_r[0]),
      .out_rem   (sq_rem[0]),
      .out_pass  (sq_p[0])
   );
   assign sq_res[0] = '0;

   // square root of 1 - s^2, one root bit per cell
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      qte_sqrt_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[k]),
         .in_ready  (sq_r[k]),
         .in_rem    (sq_rem[k]),
         .in_res    (sq_res[k]),
         .in_pass   (sq_p[k]),
         .out_valid (sq_v[k+1]),
         .out_ready (sq_r[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_res   (sq_res[k+1]),
         .out_pass  (sq_p[k+1])
      );
   end

   // pitch lane is the vector (sqrt(1-s^2), s)
   always_comb begin
      cd_first.roll       = sq_p[SQ_STEPS].roll;
      cd_first.yaw        = sq_p[SQ_STEPS].yaw;
      cd_first.clip       = sq_p[SQ_STEPS].clip;
      cd_first.pitch.x    = CW'(sq_res[SQ_STEPS]);
      cd_first.pitch.y    = CW'(sq_p[SQ_STEPS].s);
      cd_first.pitch.ang  = '0;
      cd_first.pitch.spec = (sq_res[SQ_STEPS] == '0) ?
                            sign_spec(QW'(sq_p[SQ_STEPS].s)) : SPEC_NONE;
   end
   assign cd_d[0]        = cd_first;
   assign cd_v[0]        = sq_v[SQ_STEPS];
   assign sq_r[SQ_STEPS] = cd_r[0];

   // CORDIC iterations
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      qte_cordic_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cd_v[k]),
         .in_ready  (cd_r[k]),
         .in_data   (cd_d[k]),
         .out_valid (cd_v[k+1]),
         .out_ready (cd_r[k+1]),
         .out_data  (cd_d[k+1])
      );
   end

   // Q.30 to Q2.13, nearest with halves away from zero, clamped
   function automatic logic signed [OW-1:0] finish(input lane_type l);
      logic [AW-1:0]        m;
      logic signed [OW-1:0] r;
      begin
         m = l.ang[AW-1] ? AW'(-l.ang) : AW'(l.ang);
         m = (m + (AW'(1) << 16)) >> 17;
         if (m > AW'(HALF_PI_Q13))
            m = AW'(HALF_PI_Q13);
         r = l.ang[AW-1] ? -$signed(m[OW-1:0]) : $signed(m[OW-1:0]);
         unique case (l.spec)
            SPEC_POS:  r = HALF_PI_Q13;
            SPEC_NEG:  r = -HALF_PI_Q13;
            SPEC_ZERO: r = '0;
            default:   ;
         endcase
         return r;
      end
   endfunction

   // output register
   assign out_ready               = !rsp_valid_ff || !rsp_stall;
   assign cd_r[CORDIC_STEPS]      = out_ready;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_ready)
         rsp_valid_ff <= cd_v[CORDIC_STEPS];
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         roll_ff  <= finish(cd_d[CORDIC_STEPS].roll);
         pitch_ff <= finish(cd_d[CORDIC_STEPS].pitch);
         yaw_ff   <= finish(cd_d[CORDIC_STEPS].yaw);
         clip_ff  <= cd_d[CORDIC_STEPS].clip;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_clipped = clip_ff;

`ifndef NO_ASSERTIONS
   // a saturated asin argument always lands on a pole
   a_clip_pole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch_clipped |->
         (rsp_pitch_angle == HALF_PI_Q13) || (rsp_pitch_angle == -HALF_PI_Q13))
      else $error("clipped pitch not at a pole");

   // clamping keeps every angle within a quarter turn
   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= HALF_PI_Q13) && (rsp_roll_angle >= -HALF_PI_Q13))
      else $error("roll out of range");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_angle <= HALF_PI_Q13) && (rsp_yaw_angle >= -HALF_PI_Q13))
      else $error("yaw out of range");

   // input stalls only while the output holds an item it cannot hand off
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");
`endif

endmodule

/* hw/rtl/qte_front.sv */
// Front end: component products, ratio terms and asin argument, four stages.
// Depends on qte_pkg.
module qte_front #(
   parameter int DATA_WIDTH = qte_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [DATA_WIDTH-1:0]  quat_w,
   input  logic signed [DATA_WIDTH-1:0]  quat_x,
   input  logic signed [DATA_WIDTH-1:0]  quat_y,
   input  logic signed [DATA_WIDTH-1:0]  quat_z,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [qte_pkg::RW-1:0]        out_rem,
   output qte_pkg::sq_pass_type          out_pass
);
   import qte_pkg::*;

   localparam int PRW   = 2 * DATA_WIDTH;
   localparam int SHR   = 2 * (DATA_WIDTH - 2) - 28;
   localparam int SHR_R = (SHR > 0) ? SHR : 0;
   localparam int SHR_L = (SHR < 0) ? -SHR : 0;

   // product brought to Q.28
   function automatic logic signed [PW-1:0] prod28(input logic signed [DATA_WIDTH-1:0] a,
                                                   input logic signed [DATA_WIDTH-1:0] b);
      logic signed [PRW-1:0] p;
      logic signed [63:0]    e;
      begin
         p = a * b;
         e = 64'(p);
         e = (e >>> SHR_R) <<< SHR_L;
         return e[PW-1:0];
      end
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;

   logic signed [PW-1:0] yz_ff, wx_ff, xx_ff, yy_ff, xy_ff, wz_ff, zz_ff, xz_ff, wy_ff;
   logic signed [QW-1:0] rnum_ff, rden_ff, ynum_ff, yden_ff, s_ff;
   lane_type             roll3_ff, yaw3_ff;
   logic signed [SW-1:0] s3_ff;
   logic                 clip3_ff;
   logic [RW-1:0]        rem_ff;
   sq_pass_type          pass_ff;

   lane_type             roll_in, yaw_in;
   logic signed [SW-1:0] s_in;
   logic                 clip_in;
   logic signed [2*SW-1:0] sq;

   // stage ready chain
   assign r4 = !v4_ff || out_ready;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   // lane setup: forced result on zero denominator, sign fold on negative one
   function automatic lane_type mk_lane(input logic signed [QW-1:0] num,
                                        input logic signed [QW-1:0] den);
      lane_type l;
      begin
         l.ang = '0;
         if (den == '0) begin
            l.spec = sign_spec(num);
            l.x    = den;
            l.y    = num;
         end else if (den[QW-1]) begin
            l.spec = SPEC_NONE;
            l.x    = -den;
            l.y    = -num;
         end else begin
            l.spec = SPEC_NONE;
            l.x    = den;
            l.y    = num;
         end
         return l;
      end
   endfunction

   always_comb begin
      roll_in = mk_lane(rnum_ff, rden_ff);
      yaw_in  = mk_lane(ynum_ff, yden_ff);
      if (s_ff > ONE_Q28) begin
         s_in    = SW'(ONE_Q28);
         clip_in = 1'b1;
      end else if (s_ff < -ONE_Q28) begin
         s_in    = SW'(-ONE_Q28);
         clip_in = 1'b1;
      end else begin
         s_in    = s_ff[SW-1:0];
         clip_in = 1'b0;
      end
   end

   assign sq = s3_ff * s3_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (r1) begin
         yz_ff <= prod28(quat_y, quat_z);
         wx_ff <= prod28(quat_w, quat_x);
         xx_ff <= prod28(quat_x, quat_x);
         yy_ff <= prod28(quat_y, quat_y);
         xy_ff <= prod28(quat_x, quat_y);
         wz_ff <= prod28(quat_w, quat_z);
         zz_ff <= prod28(quat_z, quat_z);
         xz_ff <= prod28(quat_x, quat_z);
         wy_ff <= prod28(quat_w, quat_y);
      end
      if (r2) begin
         rnum_ff <= (QW'(yz_ff) + QW'(wx_ff)) <<< 1;
         rden_ff <= ONE_Q28 - ((QW'(xx_ff) + QW'(yy_ff)) <<< 1);
         ynum_ff <= (QW'(xy_ff) - QW'(wz_ff)) <<< 1;
         yden_ff <= ONE_Q28 - ((QW'(yy_ff) + QW'(zz_ff)) <<< 1);
         s_ff    <= (QW'(wy_ff) - QW'(xz_ff)) <<< 1;
      end
      if (r3) begin
         roll3_ff <= roll_in;
         yaw3_ff  <= yaw_in;
         s3_ff    <= s_in;
         clip3_ff <= clip_in;
      end
      if (r4) begin
         rem_ff       <= (RW'(1) << SQ_TOP) - RW'(sq);
         pass_ff.roll <= roll3_ff;
         pass_ff.yaw  <= yaw3_ff;
         pass_ff.s    <= s3_ff;
         pass_ff.clip <= clip3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_rem   = rem_ff;
   assign out_pass  = pass_ff;

endmodule

/* hw/rtl/qte_sqrt_cell.sv */
// One bit of the restoring square root, with the rest of the item riding along.
// Depends on qte_pkg.
module qte_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [qte_pkg::RW-1:0] in_rem,
   input  logic [qte_pkg::RW-1:0] in_res,
   input  qte_pkg::sq_pass_type   in_pass,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [qte_pkg::RW-1:0] out_rem,
   output logic [qte_pkg::RW-1:0] out_res,
   output qte_pkg::sq_pass_type   out_pass
);
   import qte_pkg::*;

   localparam logic [RW-1:0] BIT = RW'(1) << (SQ_TOP - 2 * STEP);

   logic          v_ff;
   logic [RW-1:0] rem_ff, res_ff, rem_in, res_in, trial;
   sq_pass_type   pass_ff;

   assign in_ready = !v_ff || out_ready;

   // trial subtract of the next root bit
   always_comb begin
      trial = in_res + BIT;
      if (in_rem >= trial) begin
         rem_in = in_rem - trial;
         res_in = (in_res >> 1) + BIT;
      end else begin
         rem_in = in_rem;
         res_in = in_res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= 1'b0;
      else if (in_ready)
         v_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         res_ff  <= res_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = v_ff;
   assign out_rem   = rem_ff;
   assign out_res   = res_ff;
   assign out_pass  = pass_ff;

endmodule

/* hw/rtl/qte_cordic_cell.sv */
// One vectoring CORDIC iteration applied to the roll, pitch and yaw lanes.
// Depends on qte_pkg.
module qte_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qte_pkg::cd_data_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qte_pkg::cd_data_type out_data
);
   import qte_pkg::*;

   localparam logic signed [AW-1:0] ATAN = atan_q30(STEP);

   // rotate toward the x axis, positive direction when y is not negative
   function automatic lane_type rot(input lane_type l);
      logic signed [CW-1:0] xs, ys;
      lane_type r;
      begin
         xs = $signed(l.x) >>> STEP;
         ys = $signed(l.y) >>> STEP;
         r  = l;
         if (!l.y[CW-1]) begin
            r.x   = l.x + ys;
            r.y   = l.y - xs;
            r.ang = l.ang + ATAN;
         end else begin
            r.x   = l.x - ys;
            r.y   = l.y + xs;
            r.ang = l.ang - ATAN;
         end
         return r;
      end
   endfunction

   logic        v_ff;
   cd_data_type d_ff, d_in;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      d_in.roll  = rot(in_data.roll);
      d_in.pitch = rot(in_data.pitch);
      d_in.yaw   = rot(in_data.yaw);
      d_in.clip  = in_data.clip;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= 1'b0;
      else if (in_ready)
         v_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready)
         d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

/* tb/sv/tb_quaternion_to_euler_core.sv */
// Testbench for quaternion_to_euler_core: drives quaternions, predicts the Euler
// angles with a bit-exact integer model and checks each result in order.
// Depends on qte_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_core;
   import qte_pkg::*;

   localparam int DW     = 16;
   localparam int STEPS  = 16;
   localparam int LAT    = 34 + STEPS;
   localparam longint ONE28 = 64'sd268435456;
   localparam longint HPI   = 12868;

   typedef struct packed {
      logic signed [OW-1:0] roll;
      logic signed [OW-1:0] pitch;
      logic signed [OW-1:0] yaw;
      logic                 clip;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [DW-1:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [OW-1:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;
   logic rsp_pitch_clipped;

   euler_type angle_queue[$];
   int  fail_count = 0;
   bit  sink_busy = 1'b1;

   always #4 clock = ~clock;

   quaternion_to_euler_core #(.DATA_WIDTH(DW), .CORDIC_STEPS(STEPS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_roll_angle(rsp_roll_angle), .rsp_pitch_angle(rsp_pitch_angle),
      .rsp_yaw_angle(rsp_yaw_angle), .rsp_pitch_clipped(rsp_pitch_clipped)
   );

   // arithmetic shift, floor toward minus infinity
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   // product of two Q1.14 values in Q.28
   function automatic longint mul_q28(longint a, longint b);
      int sh;
      sh = 2 * (DW - 2) - 28;
      if (sh >= 0) return shr_floor(a * b, sh);
      return (a * b) <<< (-sh);
   endfunction

   // Q.30 radians to Q2.13, round half away, clamp
   function automatic longint round_q13(longint a);
      longint m;
      m = (a < 0) ? -a : a;
      m = (m + (64'sd1 << 16)) >>> 17;
      m = (a < 0) ? -m : m;
      if (m > HPI) m = HPI;
      if (m < -HPI) m = -HPI;
      return m;
   endfunction

   function automatic longint vector_angle(longint xv, longint yv);
      longint ang, xs, ys;
      ang = 0;
      for (int i = 0; i < STEPS; i++) begin
         xs = shr_floor(xv, i);
         ys = shr_floor(yv, i);
         if (yv >= 0) begin
            xv = xv + ys; yv = yv - xs; ang += longint'(atan_q30(i));
         end else begin
            xv = xv - ys; yv = yv + xs; ang -= longint'(atan_q30(i));
         end
      end
      return ang;
   endfunction

   function automatic longint ratio_angle(longint num, longint den);
      if (den == 0) return (num > 0) ? HPI : ((num < 0) ? -HPI : 0);
      if (den < 0) begin
         den = -den; num = -num;
      end
      return round_q13(vector_angle(den, num));
   endfunction

   function automatic longint floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv; res = (res >> 1) + bitv;
         end else res >>= 1;
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic euler_type predict_euler(longint w, longint x, longint y, longint z);
      euler_type e;
      longint s, c, p;
      e.roll = OW'(ratio_angle(2 * (mul_q28(y, z) + mul_q28(w, x)),
                               ONE28 - 2 * (mul_q28(x, x) + mul_q28(y, y))));
      e.yaw  = OW'(ratio_angle(2 * (mul_q28(x, y) - mul_q28(w, z)),
                               ONE28 - 2 * (mul_q28(y, y) + mul_q28(z, z))));
      s = -2 * (mul_q28(x, z) - mul_q28(w, y));
      e.clip = 1'b0;
      if (s > ONE28) begin
         s = ONE28; e.clip = 1'b1;
      end else if (s < -ONE28) begin
         s = -ONE28; e.clip = 1'b1;
      end
      c = floor_sqrt(longint'(ONE28 * ONE28) - s * s);
      if (c == 0) p = (s > 0) ? HPI : ((s < 0) ? -HPI : 0);
      else p = round_q13(vector_angle(c, s));
      e.pitch = OW'(p);
      return e;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_quat(logic [DW-1:0] w, logic [DW-1:0] x,
                            logic [DW-1:0] y, logic [DW-1:0] z, bit with_gaps);
      int g;
      g = with_gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      angle_queue.push_back(predict_euler(longint'($signed(w)), longint'($signed(x)),
                                          longint'($signed(y)), longint'($signed(z))));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (angle_queue.size() != 0) @(negedge clock);
   endtask

   // extremes, unit axes, gimbal lock and asin saturation
   task automatic test_directed();
      logic [DW-1:0] v[6];
      v = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd11585, -16'sd11585, 16'h8000};
      send_quat(16'sd16384, 0, 0, 0, 0);
      send_quat(0, 16'sd16384, 0, 0, 0);
      send_quat(0, 0, 16'sd16384, 0, 0);
      send_quat(0, 0, 0, 16'sd16384, 0);
      send_quat(0, 0, 0, 0, 0);
      send_quat(16'sd11585, 0, 16'sd11585, 0, 0);
      send_quat(16'sd11585, 0, -16'sd11585, 0, 0);
      send_quat(16'sd16384, 0, 16'sd16384, 0, 0);
      send_quat(16'sd16384, 0, -16'sd16384, 0, 0);
      send_quat(16'sd11585, 16'sd11585, 0, 0, 0);
      send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
      send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0);
      for (int i = 0; i < 10; i++)
         send_quat(v[$urandom_range(0, 5)], v[$urandom_range(0, 5)],
                   v[$urandom_range(0, 5)], v[$urandom_range(0, 5)], 0);
   endtask

   // mostly components within +-1.0 in Q1.14, the rest any bit pattern
   task automatic test_random(int count);
      int a, b, c, d;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            a = $urandom_range(0, 32768) - 16384;
            b = $urandom_range(0, 32768) - 16384;
            c = $urandom_range(0, 32768) - 16384;
            d = $urandom_range(0, 32768) - 16384;
            if ($urandom_range(0, 3) == 0) c = a;
            send_quat(DW'(a), DW'(b), DW'(c), DW'(d), 1);
         end else
            send_quat(DW'($urandom), DW'($urandom), DW'($urandom), DW'($urandom), 1);
         if (i == count / 2) wait_drained();
      end
   endtask

   // back to back with no gaps while the sink stalls
   task automatic test_burst(int count);
      for (int i = 0; i < count; i++)
         send_quat(DW'($urandom), DW'($urandom), DW'($urandom), DW'($urandom), 0);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (!sink_busy) rsp_stall <= 1'b0;
      else if ($urandom_range(0, 99) < 3) rsp_stall <= 1'b1;
      else if (rsp_stall && $urandom_range(0, 99) < 70) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < 20);
   end

   // result checker
   always @(posedge clock) begin
      euler_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angle_queue.size() == 0) begin
            $error("result with nothing expected");
            fail_count++;
         end else begin
            e = angle_queue.pop_front();
            if (rsp_roll_angle !== e.roll) begin
               $error("roll_angle expected %0d got %0d", e.roll, rsp_roll_angle);
               fail_count++;
            end
            if (rsp_pitch_angle !== e.pitch) begin
               $error("pitch_angle expected %0d got %0d", e.pitch, rsp_pitch_angle);
               fail_count++;
            end
            if (rsp_yaw_angle !== e.yaw) begin
               $error("yaw_angle expected %0d got %0d", e.yaw, rsp_yaw_angle);
               fail_count++;
            end
            if (rsp_pitch_clipped !== e.clip) begin
               $error("pitch_clipped expected %0b got %0b", e.clip, rsp_pitch_clipped);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1000);
      test_burst(120);
      wait_drained();
      sink_busy = 1'b0;
      repeat (LAT + 10) @(negedge clock);
      if (fail_count == 0 && angle_queue.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
